/* hw/rtl/mstc_pkg.sv */
// Shared types and constants for the minimum spanning tree cost block.
package mstc_pkg;
   localparam int VERTICES    = 8;
   localparam int MAX_EDGES   = 32;
   localparam int WEIGHT_BITS = 16;
   localparam int VBITS       = $clog2(VERTICES);
   localparam int EBITS       = $clog2(MAX_EDGES);
   localparam int CBITS       = EBITS + 1;
   localparam int COST_BITS   = 19;
   localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

   localparam logic ACT_INSERT  = 1'b0;
   localparam logic ACT_COMPUTE = 1'b1;

   typedef struct packed {
      logic [VBITS-1:0]       a;
      logic [VBITS-1:0]       b;
      logic [WEIGHT_BITS-1:0] w;
   } edge_type;

   typedef struct packed {
      logic insert;
      logic clear;
      logic sort_start;
      logic sort_step;
      logic uf_start;
      logic uf_step;
   } cmd_type;

   typedef struct packed {
      logic sort_done;
      logic uf_done;
   } status_type;
endpackage

/* hw/rtl/mstc_datapath.sv */
// Datapath: edge store, odd-even sort passes, and union-find over the parent table.
module mstc_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mstc_pkg::cmd_type                      cmd,
   input  mstc_pkg::edge_type                     in_edge,
   output mstc_pkg::status_type                   status,
   output logic [mstc_pkg::COST_BITS-1:0]         cost,
   output logic [2:0]                             used,
   output logic                                   dropped
);
   mstc_pkg::edge_type store_ff [mstc_pkg::MAX_EDGES];
   logic [mstc_pkg::CBITS-1:0] count_ff;
   logic [mstc_pkg::VBITS-1:0] parent_ff [mstc_pkg::VERTICES];
   logic [mstc_pkg::COST_BITS-1:0] cost_ff;
   logic [2:0] used_ff;
   logic dropped_ff;
   logic [mstc_pkg::CBITS-1:0] pass_ff;
   logic [mstc_pkg::CBITS-1:0] idx_ff;

   assign cost = cost_ff;
   assign used = used_ff;
   assign dropped = dropped_ff;
   assign status.sort_done = (pass_ff >= count_ff);
   assign status.uf_done = (idx_ff >= count_ff);

   // Root lookup of the current edge; the chain has at most VERTICES links.
   mstc_pkg::edge_type cur;
   logic [mstc_pkg::VBITS-1:0] ra, rb;
   logic [mstc_pkg::COST_BITS:0] csum;
   always_comb begin
      cur = store_ff[idx_ff[mstc_pkg::EBITS-1:0]];
      ra = cur.a;
      rb = cur.b;
      for (int k = 0; k < mstc_pkg::VERTICES; k++) begin
         ra = parent_ff[ra];
         rb = parent_ff[rb];
      end
      csum = {1'b0, cost_ff} + (mstc_pkg::COST_BITS+1)'(cur.w);
   end

   always_ff @(posedge clock) begin
      if (cmd.insert && count_ff < mstc_pkg::CBITS'(mstc_pkg::MAX_EDGES))
         store_ff[count_ff[mstc_pkg::EBITS-1:0]] <= in_edge;
      if (cmd.sort_step) begin
         for (int i = 0; i + 1 < mstc_pkg::MAX_EDGES; i++) begin
            if ((i % 2) == int'(pass_ff[0]) && (i + 1) < int'(count_ff)
                && store_ff[i].w > store_ff[i+1].w) begin
               store_ff[i]   <= store_ff[i+1];
               store_ff[i+1] <= store_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         cost_ff <= '0;
         used_ff <= '0;
         dropped_ff <= 1'b0;
         pass_ff <= '0;
         idx_ff <= '0;
         for (int v = 0; v < mstc_pkg::VERTICES; v++)
            parent_ff[v] <= mstc_pkg::VBITS'(v);
      end else begin
         if (cmd.insert) begin
            if (count_ff < mstc_pkg::CBITS'(mstc_pkg::MAX_EDGES))
               count_ff <= count_ff + 1'b1;
            else
               dropped_ff <= 1'b1;
         end
         if (cmd.sort_start) pass_ff <= '0;
         if (cmd.sort_step) pass_ff <= pass_ff + 1'b1;
         if (cmd.uf_start) idx_ff <= '0;
         if (cmd.uf_step) begin
            idx_ff <= idx_ff + 1'b1;
            if (ra != rb) begin
               parent_ff[cur.a] <= (ra < rb) ? ra : rb;
               parent_ff[cur.b] <= (ra < rb) ? ra : rb;
               if (ra < rb) parent_ff[rb] <= ra;
               else parent_ff[ra] <= rb;
               cost_ff <= csum[mstc_pkg::COST_BITS] ? mstc_pkg::COST_MAX
                                                   : csum[mstc_pkg::COST_BITS-1:0];
               if (used_ff != 3'd7) used_ff <= used_ff + 1'b1;
            end else begin
               parent_ff[cur.a] <= ra;
               parent_ff[cur.b] <= rb;
            end
         end
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mstc_pkg::CBITS'(mstc_pkg::MAX_EDGES)) else $error("count overflow");
   a_cost_mono: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.uf_step) && !$past(cmd.clear) |-> cost_ff >= $past(cost_ff))
      else $error("cost decreased");
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.uf_step && !cmd.clear |=> $stable(used_ff)) else $error("used changed");
endmodule

/* hw/rtl/mstc_control.sv */
// Controller: sequences insert, sort passes, union-find walk and result delivery.
module mstc_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 action,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  mstc_pkg::status_type status,
   output mstc_pkg::cmd_type    cmd
);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_SORT = 4'b0010, S_UF = 4'b0100, S_OUT = 4'b1000
   } state_type;
   state_type state_ff, state_in;
   logic acc;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign acc = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (acc && action == mstc_pkg::ACT_INSERT) cmd.insert = 1'b1;
            if (acc && action == mstc_pkg::ACT_COMPUTE) begin
               cmd.sort_start = 1'b1;
               state_in = S_SORT;
            end
         end
         S_SORT: begin
            if (status.sort_done) begin
               cmd.uf_start = 1'b1;
               state_in = S_UF;
            end else cmd.sort_step = 1'b1;
         end
         S_UF: begin
            if (status.uf_done) state_in = S_OUT;
            else cmd.uf_step = 1'b1;
         end
         S_OUT: begin
            if (rsp_tready) begin
               cmd.clear = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("both sides open");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result lost");
endmodule

/* hw/rtl/minimum_spanning_tree_cost.sv */
// Top level of the minimum spanning tree cost block.
// An insert beat stores one edge. A compute beat sorts the stored edges by
// weight with odd-even passes and then walks them with union-find; the result
// waits in its register until taken.
// Synchronous reset empties the store and sets each parent to itself.
module minimum_spanning_tree_cost (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // vertex_a[2:0], vertex_b[5:3], weight[21:6]
   input  logic        req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // total_cost[18:0], edges_used[21:19], edges_dropped[22]
);
   mstc_pkg::cmd_type cmd;
   mstc_pkg::status_type status;
   mstc_pkg::edge_type in_edge;
   logic [mstc_pkg::COST_BITS-1:0] cost;
   logic [2:0] used;
   logic dropped;

   assign in_edge.a = req_tdata[2:0];
   assign in_edge.b = req_tdata[5:3];
   assign in_edge.w = req_tdata[21:6];
   assign rsp_tdata = {1'b0, dropped, used, cost};

   mstc_control u_ctl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .action(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .status(status), .cmd(cmd));

   mstc_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .in_edge(in_edge), .status(status),
      .cost(cost), .used(used), .dropped(dropped));
endmodule
